FILE: rtl/rld_pkg.sv
`default_nettype none

package rld_pkg;

  // Bit that marks a literal control byte, and the mask for its run length.
  localparam int unsigned LitFlagBit = 7;
  localparam logic [7:0]  Low7Mask   = 8'h7F;

  // Value added to a repeat control byte to give the run length.
  localparam logic [7:0]  RepeatBias = 8'd3;

  // Result status codes.
  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusHdr   = 2'd1;
  localparam logic [1:0] StatusTrunc = 2'd2;

  // Depth of the command queue between front and back.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first;
  } in_t;

  typedef struct packed {
    logic [7:0]  tile_a;
    logic [7:0]  tile_b;
    logic [7:0]  tile_c;
    logic [7:0]  tile_d;
    logic [2:0]  lanes_valid;
    logic [15:0] position;
    logic        last;
    logic [1:0]  status;
  } out_t;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_STATUS,
    CMD_REP,
    CMD_LIT
  } cmd_kind_e;

  // One command from the parser to the tile engine.
  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  value;
    logic [7:0]  count;
    logic        trunc;
    logic [1:0]  status;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/rld_front.sv
`default_nettype none

module rld_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [15:0]    map_tiles_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire rld_pkg::in_t   in_data_i,
  input  wire logic           q_full_i,
  output logic                q_push_o,
  output rld_pkg::cmd_t       q_cmd_o
);

  typedef enum logic [2:0] {
    F_WAIT,
    F_HDR,
    F_CTRL,
    F_REP,
    F_LIT
  } front_state_e;

  front_state_e state_q, state_d;
  logic [1:0]   hdr_idx_q, hdr_idx_d;
  logic [15:0]  hdr_lo_q, hdr_lo_d;
  logic         hdr_hi_nz_q, hdr_hi_nz_d;
  logic [7:0]   count_q, count_d;

  logic         accept;
  logic [7:0]   b;
  logic         hi_nz_new;
  logic [7:0]   left_new;

  // Every transfer may push one command, so the queue must have room.
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_data_i.in_byte;

  // Parse the byte stream and build commands for the tile engine.
  always_comb begin
    state_d     = state_q;
    hdr_idx_d   = hdr_idx_q;
    hdr_lo_d    = hdr_lo_q;
    hdr_hi_nz_d = hdr_hi_nz_q;
    count_d     = count_q;
    q_push_o    = 1'b0;
    q_cmd_o     = '{kind: rld_pkg::CMD_START, value: b, count: 8'd1, trunc: 1'b0,
                    status: rld_pkg::StatusOk};
    hi_nz_new   = hdr_hi_nz_q || (b != 8'd0);
    left_new    = count_q - 8'd1;
    if (accept) begin
      if (in_data_i.first) begin
        state_d     = F_HDR;
        hdr_idx_d   = 2'd1;
        hdr_lo_d    = {8'd0, b};
        hdr_hi_nz_d = 1'b0;
      end else begin
        unique case (state_q)
          F_WAIT: begin
            state_d = F_WAIT;
          end
          F_HDR: begin
            hdr_idx_d = hdr_idx_q + 2'd1;
            if (hdr_idx_q == 2'd1) begin
              hdr_lo_d[15:8] = b;
            end else begin
              hdr_hi_nz_d = hi_nz_new;
            end
            // Fourth header byte: check the tile count.
            if (hdr_idx_q == 2'd3) begin
              q_push_o = 1'b1;
              if (hi_nz_new || (hdr_lo_q != map_tiles_i)) begin
                q_cmd_o.kind   = rld_pkg::CMD_STATUS;
                q_cmd_o.status = rld_pkg::StatusHdr;
                state_d        = F_WAIT;
              end else if (map_tiles_i == 16'd0) begin
                q_cmd_o.kind   = rld_pkg::CMD_STATUS;
                q_cmd_o.status = rld_pkg::StatusOk;
                state_d        = F_WAIT;
              end else begin
                q_cmd_o.kind = rld_pkg::CMD_START;
                state_d      = F_CTRL;
              end
            end
          end
          F_CTRL: begin
            if (b[rld_pkg::LitFlagBit]) begin
              count_d = (b & rld_pkg::Low7Mask) + 8'd1;
              state_d = F_LIT;
            end else begin
              count_d = b + rld_pkg::RepeatBias;
              state_d = F_REP;
            end
          end
          F_REP: begin
            q_push_o      = 1'b1;
            q_cmd_o.kind  = rld_pkg::CMD_REP;
            q_cmd_o.count = count_q;
            state_d       = F_CTRL;
          end
          F_LIT: begin
            q_push_o      = 1'b1;
            q_cmd_o.kind  = rld_pkg::CMD_LIT;
            q_cmd_o.trunc = (left_new != 8'd0);
            count_d       = left_new;
            if (left_new == 8'd0) begin
              state_d = F_CTRL;
            end
          end
          default: begin
            state_d = F_WAIT;
          end
        endcase
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_WAIT;
      hdr_idx_q   <= 2'd0;
      hdr_lo_q    <= 16'd0;
      hdr_hi_nz_q <= 1'b0;
      count_q     <= 8'd0;
    end else begin
      state_q     <= state_d;
      hdr_idx_q   <= hdr_idx_d;
      hdr_lo_q    <= hdr_lo_d;
      hdr_hi_nz_q <= hdr_hi_nz_d;
      count_q     <= count_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rld_fifo.sv
`default_nettype none

module rld_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire rld_pkg::cmd_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output rld_pkg::cmd_t      head_o
);

  rld_pkg::cmd_t                 mem_q [rld_pkg::QDepth];
  logic [rld_pkg::QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [rld_pkg::QPtrW:0]       fill_q;
  logic                          do_push, do_pop;

  assign full_o  = (fill_q == (rld_pkg::QPtrW+1)'(rld_pkg::QDepth));
  assign empty_o = (fill_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Command storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + (rld_pkg::QPtrW)'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + (rld_pkg::QPtrW)'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + (rld_pkg::QPtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - (rld_pkg::QPtrW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rld_back.sv
`default_nettype none

module rld_back #(
  parameter int unsigned LANES = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [15:0]   map_tiles_i,
  input  wire logic          q_empty_i,
  input  wire rld_pkg::cmd_t q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output rld_pkg::out_t      out_data_o
);

  // A word holds at most four tiles whatever LANES says.
  localparam int unsigned WordLanes = (LANES > 4) ? 4 : ((LANES < 1) ? 1 : LANES);

  logic [15:0]   tile_pos_q;
  logic [1:0]    held_cnt_q;
  logic [7:0]    held_q [3];
  logic          done_q;
  logic          started_q;
  logic [7:0]    rem_q;
  logic          trunc_q;
  logic          out_valid_q;
  rld_pkg::out_t out_data_q;

  logic          can_emit;
  logic [7:0]    eff_rem;
  logic          eff_trunc;
  logic          fin;
  logic          flush;
  logic          do_tile;
  logic          do_start;
  logic          emit;
  logic [7:0]    lane [4];
  rld_pkg::out_t word;

  assign can_emit = !out_valid_q || out_ready_i;

  // Run length and overrun flag for the command at the queue head.
  always_comb begin
    if (started_q) begin
      eff_rem   = rem_q;
      eff_trunc = trunc_q;
    end else if (q_head_i.kind == rld_pkg::CMD_REP) begin
      eff_rem   = q_head_i.count;
      eff_trunc = (({1'b0, tile_pos_q} + {9'd0, q_head_i.count}) > {1'b0, map_tiles_i});
    end else begin
      eff_rem   = q_head_i.count;
      eff_trunc = q_head_i.trunc;
    end
  end

  assign fin   = (({1'b0, tile_pos_q} + 17'd1) >= {1'b0, map_tiles_i});
  assign flush = (({1'b0, held_cnt_q} + 3'd1) >= 3'(WordLanes)) || fin;

  // Lanes of a packed word: held tiles, then the new tile, then zeros.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (2'(j) < held_cnt_q) begin
        lane[j] = held_q[j];
      end else if (2'(j) == held_cnt_q) begin
        lane[j] = q_head_i.value;
      end else begin
        lane[j] = 8'd0;
      end
    end
    lane[3] = (held_cnt_q == 2'd3) ? q_head_i.value : 8'd0;
  end

  // Decide what the head command does this cycle.
  always_comb begin
    q_pop_o  = 1'b0;
    do_tile  = 1'b0;
    do_start = 1'b0;
    emit     = 1'b0;
    word     = '{tile_a: 8'd0, tile_b: 8'd0, tile_c: 8'd0, tile_d: 8'd0,
                 lanes_valid: 3'd0, position: 16'd0, last: 1'b1,
                 status: q_head_i.status};
    if (!q_empty_i) begin
      unique case (q_head_i.kind)
        rld_pkg::CMD_START: begin
          q_pop_o  = 1'b1;
          do_start = 1'b1;
        end
        rld_pkg::CMD_STATUS: begin
          if (can_emit) begin
            q_pop_o = 1'b1;
            emit    = 1'b1;
          end
        end
        rld_pkg::CMD_REP, rld_pkg::CMD_LIT: begin
          if (done_q) begin
            // The map has ended: drop what is left of the stream.
            q_pop_o = 1'b1;
          end else if (!flush || can_emit) begin
            do_tile = 1'b1;
            q_pop_o = fin || (eff_rem == 8'd1);
            emit    = flush;
            word.tile_a      = lane[0];
            word.tile_b      = lane[1];
            word.tile_c      = lane[2];
            word.tile_d      = lane[3];
            word.lanes_valid = {1'b0, held_cnt_q} + 3'd1;
            word.position    = tile_pos_q - {14'd0, held_cnt_q};
            word.last        = fin;
            word.status      = (fin && eff_trunc) ? rld_pkg::StatusTrunc
                                                  : rld_pkg::StatusOk;
          end
        end
        default: begin
          q_pop_o = 1'b1;
        end
      endcase
    end
  end

  // Tile store for a word that is not yet full.
  always_ff @(posedge clk_i) begin
    if (do_tile && !flush) begin
      held_q[held_cnt_q] <= q_head_i.value;
    end
  end

  // Map position, packing and run progress.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_pos_q <= 16'd0;
      held_cnt_q <= 2'd0;
      done_q     <= 1'b1;
      started_q  <= 1'b0;
      rem_q      <= 8'd0;
      trunc_q    <= 1'b0;
    end else begin
      if (do_start) begin
        tile_pos_q <= 16'd0;
        held_cnt_q <= 2'd0;
        done_q     <= 1'b0;
        started_q  <= 1'b0;
      end else if (do_tile) begin
        tile_pos_q <= tile_pos_q + 16'd1;
        held_cnt_q <= flush ? 2'd0 : held_cnt_q + 2'd1;
        done_q     <= fin;
        started_q  <= !q_pop_o;
        rem_q      <= eff_rem - 8'd1;
        trunc_q    <= eff_trunc;
      end
    end
  end

  // Output register: the next word may be loaded as the current one leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: rtl/run_length_map_decoder_top.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_ready_o   | rld_pkg::in_t (in_byte, first)
// out     | output    | out_valid_o/out_ready_i | rld_pkg::out_t (four tiles, status)
// cfg     | input     | cfg_valid_i/cfg_ready_o | map_tiles, 16 bits
//
// Header and control bytes yield no tile work; a literal byte gives one tile,
// a repeat byte control + 3 tiles, one tile per cycle while a command is queued
// and the output is not held, a word leaving every WordLanes tiles or at map end.
// A four-entry command queue sits between parser and engine; the parser
// stalls only when it is full, the engine only when the output register is held.
// Reset returns to waiting for a header with map_tiles at 4096.
`default_nettype none

module run_length_map_decoder_top #(
  parameter int unsigned LANES = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire rld_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output rld_pkg::out_t      out_data_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [15:0]   cfg_data_i
);

  logic [15:0]   map_tiles_q;
  logic          q_push, q_full, q_pop, q_empty;
  rld_pkg::cmd_t q_cmd, q_head;

  // Map size register, always ready for a transfer.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_tiles_q <= 16'd4096;
    end else if (cfg_valid_i && cfg_ready_o) begin
      map_tiles_q <= cfg_data_i;
    end
  end

  rld_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .map_tiles_i (map_tiles_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_cmd)
  );

  rld_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  rld_back #(
    .LANES (LANES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .map_tiles_i (map_tiles_q),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: rtl/rld_checker.sv
`default_nettype none

module rld_checker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          out_valid_o,
  input  wire logic          out_ready_i,
  input  wire rld_pkg::out_t out_data_o
);

  // A result that is held back keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A word never carries more than four tiles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.lanes_valid <= 3'd4)
    else $error("lane count above four");

  // A result without tiles closes the map.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.lanes_valid == 3'd0 |-> out_data_o.last)
    else $error("status-only result without last");

  // A truncated run is reported only on the final word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == rld_pkg::StatusTrunc |-> out_data_o.last)
    else $error("truncation flagged before the map end");

  // A header error carries no tiles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == rld_pkg::StatusHdr
      |-> out_data_o.lanes_valid == 3'd0)
    else $error("header error with tiles");

endmodule

bind run_length_map_decoder_top rld_checker u_rld_checker (.*);

`default_nettype wire
